/* src/eud_pkg.sv */
package eud_pkg;

   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_UDP      = 8'd17;
   localparam int          ETH_HDR_LEN    = 14;
   localparam int          IP_MIN_LEN     = 20;
   localparam int          UDP_HDR_LEN    = 8;
   localparam logic [3:0]  IP_VERSION_4   = 4'd4;
   localparam logic [3:0]  IHL_MIN        = 4'd5;
   localparam int          OFFSET_W       = 17;
   localparam logic [OFFSET_W-1:0] OFFSET_MAX = {OFFSET_W{1'b1}};

   // result kinds
   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_SUMMARY = 2'd1;
   localparam logic [1:0] KIND_DROP    = 2'd2;

   // drop causes, first failing check wins
   localparam logic [3:0] CAUSE_NONE       = 4'd0;
   localparam logic [3:0] CAUSE_SHORT_ETH  = 4'd1;
   localparam logic [3:0] CAUSE_ETHERTYPE  = 4'd2;
   localparam logic [3:0] CAUSE_SHORT_IP   = 4'd3;
   localparam logic [3:0] CAUSE_VER_IHL    = 4'd4;
   localparam logic [3:0] CAUSE_OPTS_CUT   = 4'd5;
   localparam logic [3:0] CAUSE_NOT_UDP    = 4'd6;
   localparam logic [3:0] CAUSE_TOTAL_LEN  = 4'd7;
   localparam logic [3:0] CAUSE_UDP_LEN    = 4'd8;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        frame_end;
      logic [31:0] stamp_seconds;
      logic [31:0] stamp_fraction;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  payload_byte;
      logic [31:0] source_address;
      logic [31:0] dest_address;
      logic [15:0] source_port;
      logic [15:0] dest_port;
      logic [15:0] payload_length;
      logic [31:0] out_seconds;
      logic [31:0] out_fraction;
      logic [3:0]  drop_cause;
      logic        verdict_last;
   } rsp_payload_type;

   // one classified byte: an optional payload byte and an optional verdict
   typedef struct packed {
      logic            pay_valid;
      logic [7:0]      pay_byte;
      logic            verd_valid;
      rsp_payload_type verdict;
   } entry_type;

endpackage

/* src/eth_ipv4_udp_deframer.sv */
// ethernet/ipv4/udp deframer: takes a captured frame one byte per item, with
// frame_end on its last byte and the capture stamps sampled on its first byte.
// udp payload bytes come out as kind-payload items while the headers seen so far
// pass every check; the last byte of a frame then yields one verdict item
// (datagram summary or drop with the first failing check), after its payload
// item if that byte is also payload. the consumer throws away a frame's payload
// items when its verdict is a drop. a new byte is taken every cycle while
// req_full is low; header parsing and classification finish in the cycle of
// acceptance and land in a queue of QUEUE_DEPTH entries, and the output stage
// drains one item per cycle while rsp_pop takes them, so a final byte that
// carries payload gives the output side a payload item and then a verdict item.
// a result passes through the queue and then the output register before it
// shows on the rsp_ ports. frames beyond 131072 bytes keep counting as that long.
module eth_ipv4_udp_deframer #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   // byte input
   input  logic                     req_push,
   output logic                     req_full,
   input  eud_pkg::req_payload_type req_data,
   // result output
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output eud_pkg::rsp_payload_type rsp_data
);
   import eud_pkg::*;

   logic      accept;
   logic      entry_push;
   entry_type entry_data;
   logic      q_full;
   logic      q_empty;
   logic      q_pop;
   entry_type q_head;

   // a byte is taken whenever the queue has room, even if it yields no item
   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   // front: offset tracking, header latching, classification
   eud_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_data   (req_data),
      .entry_push (entry_push),
      .entry_data (entry_data)
   );

   // decouples parsing from the output handshake
   eud_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (entry_push),
      .push_data (entry_data),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   // back: splits an entry into payload and verdict items, output register
   eud_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

endmodule

/* src/eud_front.sv */
module eud_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  eud_pkg::req_payload_type req_data,
   output logic                     entry_push,
   output eud_pkg::entry_type       entry_data
);
   import eud_pkg::*;

   logic [OFFSET_W-1:0] offset_ff, offset_in;
   logic [15:0] ether_ff, ether_in;
   logic [7:0]  vihl_ff, vihl_in;
   logic [7:0]  proto_ff, proto_in;
   logic [15:0] tot_ff, tot_in;
   logic [31:0] saddr_ff, saddr_in;
   logic [31:0] daddr_ff, daddr_in;
   logic [15:0] sport_ff, sport_in;
   logic [15:0] dport_ff, dport_in;
   logic [15:0] udp_ff, udp_in;
   logic [31:0] secs_ff, secs_in;
   logic [31:0] frac_ff, frac_in;

   logic [7:0]          b;
   logic [OFFSET_W-1:0] o;
   logic [5:0]          hl;
   logic [6:0]          udp0;
   logic [OFFSET_W-1:0] udp0_w;
   logic [OFFSET_W-1:0] hl_w;
   logic [OFFSET_W-1:0] udp_k;
   logic                ip_ok;
   logic                tot_ok;
   logic                udp_ok;
   logic                pay_ok;
   logic [3:0]          cause;
   rsp_payload_type     verdict;

   assign b = req_data.data_byte;
   assign o = offset_ff;

   always_comb begin
      ether_in = ether_ff;
      vihl_in  = vihl_ff;
      proto_in = proto_ff;
      tot_in   = tot_ff;
      saddr_in = saddr_ff;
      daddr_in = daddr_ff;
      secs_in  = secs_ff;
      frac_in  = frac_ff;
      if (o == '0) begin
         secs_in = req_data.stamp_seconds;
         frac_in = req_data.stamp_fraction;
      end
      if (o == OFFSET_W'(12)) ether_in = {b, ether_ff[7:0]};
      if (o == OFFSET_W'(13)) ether_in = {ether_ff[15:8], b};
      if (o == OFFSET_W'(14)) vihl_in = b;
      if (o == OFFSET_W'(16)) tot_in = {b, tot_ff[7:0]};
      if (o == OFFSET_W'(17)) tot_in = {tot_ff[15:8], b};
      if (o == OFFSET_W'(23)) proto_in = b;
      if (o >= OFFSET_W'(26) && o <= OFFSET_W'(29)) saddr_in = {saddr_ff[23:0], b};
      if (o >= OFFSET_W'(30) && o <= OFFSET_W'(33)) daddr_in = {daddr_ff[23:0], b};
   end

   // udp header position follows the ihl seen so far
   assign hl     = {vihl_in[3:0], 2'b00};
   assign udp0   = 7'(ETH_HDR_LEN) + 7'(hl);
   assign udp0_w = OFFSET_W'(udp0);
   assign hl_w   = OFFSET_W'(hl);
   assign udp_k  = o - udp0_w;
   assign ip_ok  = (vihl_in[7:4] == IP_VERSION_4) && (vihl_in[3:0] >= IHL_MIN);

   always_comb begin
      sport_in = sport_ff;
      dport_in = dport_ff;
      udp_in   = udp_ff;
      if (ip_ok && o >= udp0_w && udp_k < OFFSET_W'(6)) begin
         if (udp_k < OFFSET_W'(2))      sport_in = {sport_ff[7:0], b};
         else if (udp_k < OFFSET_W'(4)) dport_in = {dport_ff[7:0], b};
         else                           udp_in   = {udp_ff[7:0], b};
      end
   end

   assign tot_ok = OFFSET_W'(tot_in) >= hl_w + OFFSET_W'(UDP_HDR_LEN);
   assign udp_ok = (udp_in >= 16'(UDP_HDR_LEN))
                   && (OFFSET_W'(udp_in) <= OFFSET_W'(tot_in) - hl_w);
   assign pay_ok = ip_ok && ether_in == ETHERTYPE_IPV4 && proto_in == PROTO_UDP
                   && tot_ok && udp_ok
                   && o >= udp0_w + OFFSET_W'(UDP_HDR_LEN)
                   && o < udp0_w + OFFSET_W'(udp_in);

   // offsets compared against o, which is frame length minus one
   always_comb begin
      if (o < OFFSET_W'(ETH_HDR_LEN - 1))                        cause = CAUSE_SHORT_ETH;
      else if (ether_in != ETHERTYPE_IPV4)                       cause = CAUSE_ETHERTYPE;
      else if (o < OFFSET_W'(ETH_HDR_LEN + IP_MIN_LEN - 1))      cause = CAUSE_SHORT_IP;
      else if (!ip_ok)                                           cause = CAUSE_VER_IHL;
      else if (o < hl_w + OFFSET_W'(ETH_HDR_LEN - 1))            cause = CAUSE_OPTS_CUT;
      else if (proto_in != PROTO_UDP)                            cause = CAUSE_NOT_UDP;
      else if (!tot_ok || o < OFFSET_W'(tot_in) + OFFSET_W'(ETH_HDR_LEN - 1))
                                                                 cause = CAUSE_TOTAL_LEN;
      else if (!udp_ok)                                          cause = CAUSE_UDP_LEN;
      else                                                       cause = CAUSE_NONE;
   end

   always_comb begin
      verdict = '0;
      verdict.verdict_last = 1'b1;
      if (cause == CAUSE_NONE) begin
         verdict.kind           = KIND_SUMMARY;
         verdict.source_address = saddr_in;
         verdict.dest_address   = daddr_in;
         verdict.source_port    = sport_in;
         verdict.dest_port      = dport_in;
         verdict.payload_length = udp_in - 16'(UDP_HDR_LEN);
         verdict.out_seconds    = secs_in;
         verdict.out_fraction   = frac_in;
      end else begin
         verdict.kind       = KIND_DROP;
         verdict.drop_cause = cause;
      end
   end

   always_comb begin
      entry_data.pay_valid  = pay_ok;
      entry_data.pay_byte   = b;
      entry_data.verd_valid = req_data.frame_end;
      entry_data.verdict    = verdict;
      entry_push            = accept && (pay_ok || req_data.frame_end);
   end

   always_comb begin
      offset_in = offset_ff;
      if (req_data.frame_end)     offset_in = '0;
      else if (o != OFFSET_MAX)   offset_in = o + OFFSET_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         ether_ff  <= '0;
         vihl_ff   <= '0;
         proto_ff  <= '0;
         tot_ff    <= '0;
         saddr_ff  <= '0;
         daddr_ff  <= '0;
         sport_ff  <= '0;
         dport_ff  <= '0;
         udp_ff    <= '0;
         secs_ff   <= '0;
         frac_ff   <= '0;
      end else if (accept) begin
         offset_ff <= offset_in;
         ether_ff  <= ether_in;
         vihl_ff   <= vihl_in;
         proto_ff  <= proto_in;
         tot_ff    <= tot_in;
         saddr_ff  <= saddr_in;
         daddr_ff  <= daddr_in;
         sport_ff  <= sport_in;
         dport_ff  <= dport_in;
         udp_ff    <= udp_in;
         secs_ff   <= secs_in;
         frac_ff   <= frac_in;
      end
   end

endmodule

/* src/eud_queue.sv */
module eud_queue #(
   parameter int DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  eud_pkg::entry_type push_data,
   output logic               full,
   input  logic               pop,
   output logic               empty,
   output eud_pkg::entry_type head
);
   import eud_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type          slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop)      count_in = count_ff + CNT_W'(1);
      else if (!do_push && do_pop) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* src/eud_back.sv */
module eud_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_empty,
   input  eud_pkg::entry_type       q_head,
   output logic                     q_pop,
   input  logic                     rsp_pop,
   output logic                     rsp_empty,
   output eud_pkg::rsp_payload_type rsp_data
);
   import eud_pkg::*;

   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_ff, out_in;
   logic            split_ff, split_in;   // payload half of head entry already sent
   logic            load;
   rsp_payload_type pay_result;

   assign load = !out_valid_ff || rsp_pop;

   always_comb begin
      pay_result              = '0;
      pay_result.kind         = KIND_PAYLOAD;
      pay_result.payload_byte = q_head.pay_byte;
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      split_in     = split_ff;
      q_pop        = 1'b0;
      if (load) begin
         out_valid_in = !q_empty;
         if (!q_empty) begin
            if (q_head.pay_valid && !split_ff) begin
               out_in = pay_result;
               if (q_head.verd_valid) split_in = 1'b1;
               else                   q_pop    = 1'b1;
            end else begin
               out_in   = q_head.verdict;
               split_in = 1'b0;
               q_pop    = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         split_ff     <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         split_ff     <= split_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

/* verif/tb.sv */
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import eud_pkg::*;

   // byte offsets of the header fields within a frame
   localparam int OFF_ETHERTYPE = 12;
   localparam int OFF_VER_IHL   = 14;
   localparam int OFF_TOTAL_LEN = 16;
   localparam int OFF_PROTOCOL  = 23;
   localparam int OFF_SRC_ADDR  = 26;
   localparam int OFF_DST_ADDR  = 30;
   // udp length field, counted from the start of the udp header
   localparam int UDP_OFF_LENGTH = 4;
   // udp ports plus length, the part of the udp header that gets latched
   localparam int UDP_LATCHED_LEN = 6;
   localparam int IHL_MAX = 15;
   // a result passes through the queue and the output register after its byte; leave plenty of margin
   localparam int SETTLE_CYCLES = 16;
   localparam int TIMEOUT_NS = 2_000_000 * 4;

   typedef logic [7:0] frame_bytes_type[$];

   logic            clock;
   logic            reset    = 1'b1;
   logic            req_push = 1'b0;
   logic            req_full;
   req_payload_type req_data = '0;
   logic            rsp_empty;
   logic            rsp_pop  = 1'b0;
   rsp_payload_type rsp_data;

   // idle odds in percent, changed per phase
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned mismatch_count = 0;

   // parser state mirrored from the block
   logic [16:0] frame_pos  = '0;
   logic [15:0] eth_type   = '0;
   logic [7:0]  ver_ihl    = '0;
   logic [7:0]  ip_proto   = '0;
   logic [15:0] ip_len     = '0;
   logic [31:0] src_ip     = '0;
   logic [31:0] dst_ip     = '0;
   logic [15:0] udp_sport  = '0;
   logic [15:0] udp_dport  = '0;
   logic [15:0] udp_len    = '0;
   logic [31:0] held_sec   = '0;
   logic [31:0] held_frac  = '0;

   // results the block still owes, oldest first
   rsp_payload_type awaited_results[$];
   rsp_payload_type want;

   eth_ipv4_udp_deframer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // parse one accepted byte and queue the payload item and verdict it causes
   task automatic parse_byte(input req_payload_type item);
      int unsigned o, hl, udp0, tl, ul, len;
      logic [7:0]  b;
      logic [3:0]  cause;
      logic        hdr_ok;
      rsp_payload_type r;
      b = item.data_byte;
      o = frame_pos;
      // capture stamps belong to the first byte only
      if (o == 0) begin
         held_sec  = item.stamp_seconds;
         held_frac = item.stamp_fraction;
      end
      if (o == OFF_ETHERTYPE)     eth_type[15:8] = b;
      if (o == OFF_ETHERTYPE + 1) eth_type[7:0]  = b;
      if (o == OFF_VER_IHL)       ver_ihl        = b;
      if (o == OFF_TOTAL_LEN)     ip_len[15:8]   = b;
      if (o == OFF_TOTAL_LEN + 1) ip_len[7:0]    = b;
      if (o == OFF_PROTOCOL)      ip_proto       = b;
      if (o >= OFF_SRC_ADDR && o < OFF_DST_ADDR) src_ip = {src_ip[23:0], b};
      if (o >= OFF_DST_ADDR && o < OFF_DST_ADDR + 4) dst_ip = {dst_ip[23:0], b};

      hdr_ok = (ver_ihl[7:4] == IP_VERSION_4) && (ver_ihl[3:0] >= IHL_MIN);
      hl = ver_ihl[3:0] * 4;
      udp0 = ETH_HDR_LEN + hl;
      // udp header sits right behind the ip header, options included
      if (hdr_ok && o >= udp0 && o < udp0 + UDP_LATCHED_LEN) begin
         if (o < udp0 + 2)      udp_sport = {udp_sport[7:0], b};
         else if (o < udp0 + 4) udp_dport = {udp_dport[7:0], b};
         else                   udp_len   = {udp_len[7:0], b};
      end
      tl = ip_len;
      ul = udp_len;

      // payload byte while every header seen so far holds up
      if (hdr_ok && eth_type == ETHERTYPE_IPV4 && ip_proto == PROTO_UDP &&
          tl >= hl + UDP_HDR_LEN && ul >= UDP_HDR_LEN && ul <= tl - hl &&
          o >= udp0 + UDP_HDR_LEN && o - (udp0 + UDP_HDR_LEN) < ul - UDP_HDR_LEN) begin
         r = '0;
         r.kind = KIND_PAYLOAD;
         r.payload_byte = b;
         awaited_results.push_back(r);
      end

      if (item.frame_end) begin
         len = o + 1;
         // first failing check wins
         if (len < ETH_HDR_LEN)                                cause = CAUSE_SHORT_ETH;
         else if (eth_type != ETHERTYPE_IPV4)                  cause = CAUSE_ETHERTYPE;
         else if (len - ETH_HDR_LEN < IP_MIN_LEN)              cause = CAUSE_SHORT_IP;
         else if (!hdr_ok)                                     cause = CAUSE_VER_IHL;
         else if (len - ETH_HDR_LEN < hl)                      cause = CAUSE_OPTS_CUT;
         else if (ip_proto != PROTO_UDP)                       cause = CAUSE_NOT_UDP;
         else if (tl < hl + UDP_HDR_LEN || len - ETH_HDR_LEN < tl) cause = CAUSE_TOTAL_LEN;
         else if (ul < UDP_HDR_LEN || ul > tl - hl)            cause = CAUSE_UDP_LEN;
         else                                                  cause = CAUSE_NONE;
         r = '0;
         if (cause == CAUSE_NONE) begin
            r.kind           = KIND_SUMMARY;
            r.source_address = src_ip;
            r.dest_address   = dst_ip;
            r.source_port    = udp_sport;
            r.dest_port      = udp_dport;
            r.payload_length = 16'(ul - UDP_HDR_LEN);
            r.out_seconds    = held_sec;
            r.out_fraction   = held_frac;
         end else begin
            r.kind       = KIND_DROP;
            r.drop_cause = cause;
         end
         r.verdict_last = 1'b1;
         awaited_results.push_back(r);
         frame_pos = '0;
      end else if (frame_pos != OFFSET_MAX) begin
         // long frames stop counting at the saturation point
         frame_pos = frame_pos + 1'b1;
      end
   endtask

   // offer one byte, optionally after some idle cycles, and wait for acceptance
   task automatic send_byte(input req_payload_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_full) @(posedge clock);
      parse_byte(item);
      @(negedge clock);
   endtask

   // stamps only count on the first byte; the rest carry noise
   task automatic send_frame(input frame_bytes_type f, input logic [31:0] sec, frac);
      req_payload_type item;
      foreach (f[i]) begin
         item.data_byte      = f[i];
         item.frame_end      = (i == f.size() - 1);
         item.stamp_seconds  = (i == 0) ? sec  : $urandom;
         item.stamp_fraction = (i == 0) ? frac : $urandom;
         send_byte(item);
      end
   endtask

   // well-formed frame with random addresses, ports and content
   function automatic frame_bytes_type udp_frame(input int unsigned ihl, pay, pad);
      frame_bytes_type f;
      logic [15:0]  tl;
      logic [15:0]  ul;
      tl = 16'(ihl * 4 + UDP_HDR_LEN + pay);
      ul = 16'(UDP_HDR_LEN + pay);
      // mac addresses
      repeat (OFF_ETHERTYPE) f.push_back(8'($urandom));
      f.push_back(ETHERTYPE_IPV4[15:8]);
      f.push_back(ETHERTYPE_IPV4[7:0]);
      f.push_back({IP_VERSION_4, 4'(ihl)});
      // type of service
      f.push_back(8'($urandom));
      f.push_back(tl[15:8]);
      f.push_back(tl[7:0]);
      // id, fragment, ttl
      repeat (OFF_PROTOCOL - OFF_TOTAL_LEN - 2) f.push_back(8'($urandom));
      f.push_back(PROTO_UDP);
      // header checksum, then both addresses
      repeat (OFF_DST_ADDR + 4 - OFF_PROTOCOL - 1) f.push_back(8'($urandom));
      // ip options
      repeat (ihl * 4 - IP_MIN_LEN) f.push_back(8'($urandom));
      // ports
      repeat (4) f.push_back(8'($urandom));
      f.push_back(ul[15:8]);
      f.push_back(ul[7:0]);
      // udp checksum, payload, then padding
      repeat (2) f.push_back(8'($urandom));
      repeat (pay + pad) f.push_back(8'($urandom));
      return f;
   endfunction

   // damage a well-formed frame so that the given check is the first to fail
   task automatic break_frame(ref frame_bytes_type f, input logic [3:0] cause, input bit variant);
      int unsigned hl, udp0, tl, ul, keep, bound;
      hl = f[OFF_VER_IHL][3:0] * 4;
      udp0 = ETH_HDR_LEN + hl;
      tl = {f[OFF_TOTAL_LEN], f[OFF_TOTAL_LEN + 1]};
      keep = f.size();
      case (cause)
         CAUSE_SHORT_ETH: begin
            keep = variant ? ETH_HDR_LEN - 1 : $urandom_range(ETH_HDR_LEN - 1, 1);
         end
         CAUSE_ETHERTYPE: begin
            f[OFF_ETHERTYPE + variant] ^= 8'($urandom_range(255, 1));
         end
         CAUSE_SHORT_IP: begin
            keep = ETH_HDR_LEN + (variant ? IP_MIN_LEN - 1 : $urandom_range(IP_MIN_LEN - 1, 0));
         end
         CAUSE_VER_IHL: begin
            if (variant) f[OFF_VER_IHL] = {IP_VERSION_4, 4'($urandom_range(IHL_MIN - 1, 0))};
            else f[OFF_VER_IHL] = {IP_VERSION_4 ^ 4'($urandom_range(15, 1)),
                                   f[OFF_VER_IHL][3:0]};
         end
         CAUSE_OPTS_CUT: begin
            // needs options to cut into
            if (hl == IP_MIN_LEN) begin
               hl = 4 * $urandom_range(IHL_MAX, IHL_MIN + 1);
               f[OFF_VER_IHL] = {IP_VERSION_4, 4'(hl / 4)};
            end
            bound = hl - 1;
            if (bound > f.size() - ETH_HDR_LEN) bound = f.size() - ETH_HDR_LEN;
            keep = ETH_HDR_LEN + (variant ? IP_MIN_LEN : $urandom_range(bound, IP_MIN_LEN));
         end
         CAUSE_NOT_UDP: begin
            f[OFF_PROTOCOL] ^= 8'($urandom_range(255, 1));
         end
         CAUSE_TOTAL_LEN: begin
            // either too small for the headers or longer than what arrived
            tl = variant ? $urandom_range(hl + UDP_HDR_LEN - 1, 0)
                         : f.size() - ETH_HDR_LEN + $urandom_range(200, 1);
            f[OFF_TOTAL_LEN]     = 8'(tl >> 8);
            f[OFF_TOTAL_LEN + 1] = 8'(tl);
         end
         CAUSE_UDP_LEN: begin
            // either under the udp header or beyond the ip payload
            ul = variant ? $urandom_range(UDP_HDR_LEN - 1, 0) : tl - hl + $urandom_range(100, 1);
            f[udp0 + UDP_OFF_LENGTH]     = 8'(ul >> 8);
            f[udp0 + UDP_OFF_LENGTH + 1] = 8'(ul);
         end
         default: ;
      endcase
      if (keep < f.size()) f = f[0 : keep - 1];
   endtask

   // single-byte frames at the byte and stamp extremes, and a runt frame of all-ones bytes
   task automatic test_byte_extremes();
      frame_bytes_type f;
      f = '{8'h00};
      send_frame(f, 32'h0000_0000, 32'h0000_0000);
      f = '{8'hFF};
      send_frame(f, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      f = {};
      repeat (ETH_HDR_LEN - 1) f.push_back(8'hFF);
      send_frame(f, $urandom, $urandom);
   endtask

   // every drop cause, each in both of its forms
   task automatic test_drop_causes();
      frame_bytes_type f;
      for (int c = CAUSE_SHORT_ETH; c <= CAUSE_UDP_LEN; c++) begin
         for (int v = 0; v < 2; v++) begin
            f = udp_frame(v ? IHL_MAX : IHL_MIN, $urandom_range(6), 0);
            break_frame(f, 4'(c), v[0]);
            send_frame(f, $urandom, $urandom);
         end
      end
   endtask

   task automatic test_accepted_datagrams();
      frame_bytes_type f;
      logic [7:0]   fill;
      int unsigned  udp0;
      // final byte is payload: payload item, then the summary right behind
      for (int pay = 1; pay <= 3; pay++) send_frame(udp_frame(IHL_MIN, pay, 0), $urandom, $urandom);
      // empty datagram gives a summary only
      send_frame(udp_frame(IHL_MIN, 0, 0), $urandom, $urandom);
      // options ahead of the udp header, padding behind the datagram
      send_frame(udp_frame(7, 5, 6), $urandom, $urandom);
      send_frame(udp_frame(IHL_MAX, 2, 3), $urandom, $urandom);
      // endpoints and stamps all zero, then all one
      udp0 = ETH_HDR_LEN + IP_MIN_LEN;
      for (int v = 0; v < 2; v++) begin
         fill = v ? 8'hFF : 8'h00;
         f = udp_frame(IHL_MIN, 4, 0);
         for (int i = OFF_SRC_ADDR; i < OFF_DST_ADDR + 4; i++) f[i] = fill;
         for (int i = 0; i < 4; i++) f[udp0 + i] = fill;
         send_frame(f, {32{v[0]}}, {32{v[0]}});
      end
   endtask

   // mostly good datagrams with random content, the rest broken or noise
   task automatic test_random_traffic(input int unsigned send_pct, recv_pct, byte_budget);
      frame_bytes_type f;
      int unsigned  sent;
      int unsigned  pick;
      int unsigned  ihl;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      sent = 0;
      while (sent < byte_budget) begin
         ihl = ($urandom_range(3) == 0) ? $urandom_range(IHL_MAX, IHL_MIN + 1) : IHL_MIN;
         f = udp_frame(ihl, $urandom_range(12), ($urandom_range(3) == 0) ? $urandom_range(8) : 0);
         pick = $urandom_range(99);
         if (pick >= 95) begin
            f = {};
            repeat ($urandom_range(60, 1)) f.push_back(8'($urandom));
         end else if (pick >= 65) begin
            break_frame(f, 4'($urandom_range(CAUSE_UDP_LEN, CAUSE_SHORT_ETH)),
                        1'($urandom_range(1)));
         end
         send_frame(f, $urandom, $urandom);
         sent += f.size();
      end
   endtask

   // receiver stalls at random, odds set per phase
   always @(negedge clock) begin
      rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
   end

   function automatic void check_field(input string name, input logic [31:0] exp_val, got_val);
      if (got_val !== exp_val) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, got_val);
         mismatch_count++;
      end
   endfunction

   // every popped item against the oldest one owed
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (awaited_results.size() == 0) begin
            $error("kind: expected no item, got 0x%0h", rsp_data.kind);
            mismatch_count++;
         end else begin
            want = awaited_results.pop_front();
            check_field("kind",           want.kind,           rsp_data.kind);
            check_field("payload_byte",   want.payload_byte,   rsp_data.payload_byte);
            check_field("source_address", want.source_address, rsp_data.source_address);
            check_field("dest_address",   want.dest_address,   rsp_data.dest_address);
            check_field("source_port",    want.source_port,    rsp_data.source_port);
            check_field("dest_port",      want.dest_port,      rsp_data.dest_port);
            check_field("payload_length", want.payload_length, rsp_data.payload_length);
            check_field("out_seconds",    want.out_seconds,    rsp_data.out_seconds);
            check_field("out_fraction",   want.out_fraction,   rsp_data.out_fraction);
            check_field("drop_cause",     want.drop_cause,     rsp_data.drop_cause);
            check_field("verdict_last",   want.verdict_last,   rsp_data.verdict_last);
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part with a lazy receiver
      send_idle_pct = 21;
      recv_idle_pct = 71;
      test_byte_extremes();
      test_drop_causes();
      test_accepted_datagrams();

      // random part: lazy receiver, then lazy sender, then full speed
      test_random_traffic(21, 71, 90);
      test_random_traffic(71, 21, 90);
      test_random_traffic(0, 0, 90);

      // drain, then make sure nothing extra trickles out
      req_push <= 1'b0;
      while (awaited_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

   // hang guard
   initial begin
      #(TIMEOUT_NS);
      $display("tb: FAIL");
      $finish;
   end

endmodule
